[src/fcce_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the FAT cluster chain engine.
// No dependencies; imported by the controller, the datapath and the top level.
package fcce_pkg;

  // Command codes carried on the input transfer
  localparam logic [2:0] OP_WRITE    = 3'd0;
  localparam logic [2:0] OP_READ     = 3'd1;
  localparam logic [2:0] OP_CHAIN    = 3'd2;
  localparam logic [2:0] OP_CONTIG   = 3'd3;
  localparam logic [2:0] OP_FIND     = 3'd4;
  localparam logic [2:0] OP_RELOCATE = 3'd5;

  // Result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_NORUN = 2'd2;

  // Register map indexes
  localparam logic REG_TOTAL     = 1'b0;
  localparam logic REG_CHAIN_END = 1'b1;

  localparam logic [11:0] TOTAL_RST     = 12'd0;
  localparam logic [15:0] CHAIN_END_RST = 16'd65528;
  localparam logic [15:0] END_MARK      = 16'hFFFF;
  localparam int unsigned COUNT_MAX     = 8191;

  typedef enum logic [3:0] {
    S_IDLE, S_DISP, S_RDW, S_WALK, S_WALK_RD, S_SRCH_INIT, S_SRCH, S_SRCH_RD,
    S_FREE, S_FREE_RD, S_FILL, S_DONE
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;
    logic tbl_write;
    logic set_range;
    logic rd_cl;
    logic rd_load;
    logic walk_adv;
    logic walk_load;
    logic walk_end;
    logic srch_init;
    logic rd_idx;
    logic srch_eval;
    logic srch_fail;
    logic free_init;
    logic free_load;
    logic fill_init;
    logic fill_step;
    logic out_load;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [2:0] op;
    logic       idx_bad;
    logic       walk_go;
    logic       walk_bad;
    logic       walk_nonlin;
    logic       cnt_zero;
    logic       last_lt2;
    logic       hit;
    logic       pass_end;
    logic       wrap_ok;
    logic       free_go;
    logic       fill_last;
  } sts_t;

endpackage

[src/fat_cluster_chain_engine_core.sv]
`timescale 1ns / 1ps
// Top level of the FAT cluster chain engine.
// Depends on fcce_pkg, fcce_ctrl and fcce_dp.
//
// Usage:
//   Input channel (in_*): one command per transfer, taken when in_valid is
//   high and in_stall low. in_stall is high while a command is in progress.
//   Result channel (out_*): exactly one result per command, held in an output
//   register until taken (out_valid high, out_stall low). The next command is
//   accepted while a result still waits; its own result waits in DONE.
//   Configuration: APB-style port, total_clusters at 0x0, chain_end_min at
//   0x4; write only while idle. pready is tied high.
// Command steps:
//   write/unused op: straight to the result register; read: one table read.
//   chain length/contiguity: one table read per link walked.
//   find run: one table read per entry scanned, wrapping to cluster 2 once.
//   relocate: walk, search, then free each old link and write each new link.
// Throughput: one command at a time; the next is taken in the cycle after the
//   result is loaded.
// Reset: synchronous, active low; clears the controller and the configuration registers.
//   The table is not cleared and must be written before it is read.
// A stalled receiver holds the result steady; the engine waits in DONE.
module fat_cluster_chain_engine_core #(
  parameter int TABLE_DEPTH = 4096,
  parameter int CHAIN_LIMIT = 4095
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_opcode,
  input  logic [11:0] in_cluster,
  input  logic [15:0] in_entry_value,
  input  logic [12:0] in_run_length,
  input  logic [11:0] in_search_from,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_read_data,
  output logic [12:0] out_chain_count,
  output logic [11:0] out_run_start,
  output logic        out_is_linear,
  output logic [1:0]  out_status,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import fcce_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign pready = 1'b1;

  fcce_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  fcce_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .CHAIN_LIMIT (CHAIN_LIMIT)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_opcode       (in_opcode),
    .in_cluster      (in_cluster),
    .in_entry_value  (in_entry_value),
    .in_run_length   (in_run_length),
    .in_search_from  (in_search_from),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .cmd             (cmd),
    .sts             (sts),
    .out_read_data   (out_read_data),
    .out_chain_count (out_chain_count),
    .out_run_start   (out_run_start),
    .out_is_linear   (out_is_linear),
    .out_status      (out_status)
  );

endmodule

[src/fcce_ctrl.sv]
`timescale 1ns / 1ps
// Controller state machine for the FAT cluster chain engine.
// Depends on fcce_pkg; drives the datapath command struct and both handshakes.
module fcce_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  input  fcce_pkg::sts_t sts,
  output fcce_pkg::cmd_t cmd
);
  import fcce_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;
  logic   walk_stop;

  assign out_free  = !out_valid_r || !out_stall;
  assign walk_stop = !sts.walk_go || sts.walk_bad || sts.walk_nonlin;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_DISP;
      S_DISP: begin
        case (sts.op)
          OP_READ:     state_nxt = sts.idx_bad ? S_DONE : S_RDW;
          OP_CHAIN,
          OP_CONTIG,
          OP_RELOCATE: state_nxt = S_WALK;
          OP_FIND:     state_nxt = S_SRCH_INIT;
          default:     state_nxt = S_DONE;
        endcase
      end
      S_RDW: state_nxt = S_DONE;
      S_WALK: begin
        if (walk_stop) begin
          if (sts.op == OP_RELOCATE && !sts.walk_bad && !sts.cnt_zero) begin
            state_nxt = S_SRCH_INIT;
          end else begin
            state_nxt = S_DONE;
          end
        end else begin
          state_nxt = S_WALK_RD;
        end
      end
      S_WALK_RD:   state_nxt = S_WALK;
      S_SRCH_INIT: state_nxt = sts.last_lt2 ? S_DONE : S_SRCH;
      S_SRCH:      state_nxt = S_SRCH_RD;
      S_SRCH_RD: begin
        if (sts.hit) begin
          state_nxt = (sts.op == OP_RELOCATE) ? S_FREE : S_DONE;
        end else if (sts.pass_end && !sts.wrap_ok) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_SRCH;
        end
      end
      S_FREE:    state_nxt = sts.free_go ? S_FREE_RD : S_FILL;
      S_FREE_RD: state_nxt = S_FREE;
      S_FILL:    if (sts.fill_last) state_nxt = S_DONE;
      S_DONE:    if (out_free) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd = '0;
    case (state_r)
      S_IDLE: cmd.accept = in_valid;
      S_DISP: begin
        case (sts.op)
          OP_WRITE: begin
            cmd.set_range = sts.idx_bad;
            cmd.tbl_write = !sts.idx_bad;
          end
          OP_READ: begin
            cmd.set_range = sts.idx_bad;
            cmd.rd_cl     = !sts.idx_bad;
          end
          default: ;
        endcase
      end
      S_RDW: cmd.rd_load = 1'b1;
      S_WALK: begin
        cmd.walk_end = walk_stop;
        cmd.walk_adv = !walk_stop;
      end
      S_WALK_RD: cmd.walk_load = 1'b1;
      S_SRCH_INIT: begin
        cmd.srch_init = 1'b1;
        cmd.srch_fail = sts.last_lt2;
      end
      S_SRCH: cmd.rd_idx = 1'b1;
      S_SRCH_RD: begin
        cmd.srch_eval = 1'b1;
        cmd.srch_fail = !sts.hit && sts.pass_end && !sts.wrap_ok;
        cmd.free_init = sts.hit && (sts.op == OP_RELOCATE);
      end
      S_FREE:    cmd.fill_init = !sts.free_go;
      S_FREE_RD: cmd.free_load = 1'b1;
      S_FILL:    cmd.fill_step = 1'b1;
      S_DONE:    cmd.out_load = out_free;
      default: ;
    endcase
  end

  // Hold the result valid until the receiver takes it
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    if (cmd.out_load) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[src/fcce_dp.sv]
`timescale 1ns / 1ps
// Datapath of the FAT cluster chain engine: cluster table, walk and search
// registers, configuration registers and result registers. Depends on fcce_pkg.
module fcce_dp #(
  parameter int TABLE_DEPTH = 4096,
  parameter int CHAIN_LIMIT = 4095
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic [2:0]     in_opcode,
  input  logic [11:0]    in_cluster,
  input  logic [15:0]    in_entry_value,
  input  logic [12:0]    in_run_length,
  input  logic [11:0]    in_search_from,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [2:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  input  fcce_pkg::cmd_t cmd,
  output fcce_pkg::sts_t sts,
  output logic [15:0]    out_read_data,
  output logic [12:0]    out_chain_count,
  output logic [11:0]    out_run_start,
  output logic           out_is_linear,
  output logic [1:0]     out_status
);
  import fcce_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(CHAIN_LIMIT + 2);
  localparam int NW = (CW > 13) ? CW : 13;
  localparam logic [16:0] LAST_MAX = 17'(TABLE_DEPTH - 1);

  // Configuration
  logic [11:0] total_r;
  logic [15:0] chain_end_r;
  logic        cfg_wr;

  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r     <= TOTAL_RST;
      chain_end_r <= CHAIN_END_RST;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_TOTAL:     total_r     <= pwdata[11:0];
        REG_CHAIN_END: chain_end_r <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_TOTAL:     prdata = {20'd0, total_r};
      REG_CHAIN_END: prdata = {16'd0, chain_end_r};
      default:       prdata = '0;
    endcase
  end

  // Last valid index, clamped to the table
  logic [16:0] last_w;
  logic [15:0] last;
  assign last_w = {5'd0, total_r} + 17'd1;
  assign last   = (last_w > LAST_MAX) ? LAST_MAX[15:0] : last_w[15:0];

  // Item and working registers
  logic [2:0]    op_r;
  logic [15:0]   cl_r, val_r;
  logic [12:0]   need_in_r;
  logic [15:0]   hint_in_r;
  logic [15:0]   cur_r, prev_r, idx_r, end_r, hint_r, start_r;
  logic          first_r, fwd_r;
  logic [NW-1:0] count_r, need_r, runcnt_r, i_r;
  logic [15:0]   res_rd_r, res_rs_r;
  logic [NW-1:0] res_cnt_r;
  logic          res_lin_r;
  logic [1:0]    res_st_r;

  // Cluster table, one read port and one write port
  logic [15:0] mem [TABLE_DEPTH];
  logic [15:0] rdata_r;
  logic [15:0] raddr, waddr, wdata, fill_val;
  logic        re, we;

  assign fill_val = ((i_r + NW'(1)) < count_r) ? (res_rs_r + 16'(i_r) + 16'd1) : END_MARK;

  always_comb begin
    raddr = cur_r;
    if (cmd.rd_cl)  raddr = cl_r;
    if (cmd.rd_idx) raddr = idx_r;
    waddr = cl_r;
    wdata = val_r;
    if (cmd.free_load) begin
      waddr = cur_r;
      wdata = 16'd0;
    end
    if (cmd.fill_step) begin
      waddr = res_rs_r + 16'(i_r);
      wdata = fill_val;
    end
  end

  assign re = cmd.rd_cl || cmd.rd_idx || cmd.walk_adv || (cmd.fill_init == 1'b0 && sts.free_go
              && cmd.free_load == 1'b0 && cmd.walk_end == 1'b0 && cmd.srch_eval == 1'b0
              && cmd.accept == 1'b0 && cmd.fill_step == 1'b0);
  assign we = cmd.tbl_write || cmd.free_load || cmd.fill_step;

  always_ff @(posedge clk) begin
    if (we) mem[waddr[AW-1:0]] <= wdata;
    if (re) rdata_r <= mem[raddr[AW-1:0]];
  end

  // Status toward the controller
  logic links_on, cur_bad, rd_zero;
  assign links_on = (cur_r >= 16'd2) && (cur_r < chain_end_r);
  assign cur_bad  = cur_r > last;
  assign rd_zero  = (rdata_r == 16'd0);

  always_comb begin
    sts.op          = op_r;
    sts.idx_bad     = cl_r > last;
    sts.walk_go     = links_on && (count_r <= NW'(CHAIN_LIMIT));
    sts.walk_bad    = sts.walk_go && cur_bad;
    sts.walk_nonlin = sts.walk_go && !cur_bad && (op_r == OP_CONTIG) && !first_r
                      && (cur_r != prev_r + 16'd1);
    sts.cnt_zero    = (count_r == '0);
    sts.last_lt2    = last < 16'd2;
    sts.hit         = rd_zero && ((runcnt_r + NW'(1)) >= need_r);
    sts.pass_end    = (idx_r == end_r);
    sts.wrap_ok     = fwd_r && (hint_r > 16'd2);
    sts.free_go     = (i_r < count_r) && links_on && !cur_bad;
    sts.fill_last   = ((i_r + NW'(1)) == count_r);
  end

  // Search start, normalised
  logic [15:0] hint_sel;
  always_comb begin
    hint_sel = (op_r == OP_FIND) ? hint_in_r : 16'd2;
    if (hint_sel < 16'd2 || hint_sel > last) hint_sel = 16'd2;
  end

  always_ff @(posedge clk) begin
    // Latch the item and clear results
    if (cmd.accept) begin
      op_r      <= in_opcode;
      cl_r      <= {4'd0, in_cluster};
      val_r     <= in_entry_value;
      need_in_r <= in_run_length;
      hint_in_r <= {4'd0, in_search_from};
      cur_r     <= {4'd0, in_cluster};
      count_r   <= '0;
      first_r   <= 1'b1;
      res_rd_r  <= 16'd0;
      res_cnt_r <= '0;
      res_rs_r  <= 16'd0;
      res_lin_r <= 1'b0;
      res_st_r  <= ST_OK;
    end
    if (cmd.set_range) res_st_r <= ST_RANGE;
    if (cmd.rd_load)   res_rd_r <= rdata_r;
    // Advance the chain walk
    if (cmd.walk_adv) begin
      prev_r  <= cur_r;
      first_r <= 1'b0;
      count_r <= count_r + NW'(1);
    end
    if (cmd.walk_load) cur_r <= rdata_r;
    if (cmd.walk_end) begin
      if (op_r != OP_CONTIG) res_cnt_r <= count_r;
      else res_lin_r <= !(sts.walk_bad || sts.walk_nonlin);
      if (sts.walk_bad) res_st_r <= ST_RANGE;
    end
    // First-fit search
    if (cmd.srch_init) begin
      if (op_r == OP_FIND) need_r <= (need_in_r == 13'd0) ? NW'(1) : NW'(need_in_r);
      else need_r <= count_r;
      hint_r   <= hint_sel;
      idx_r    <= hint_sel;
      end_r    <= last;
      fwd_r    <= 1'b1;
      runcnt_r <= '0;
    end
    if (cmd.srch_eval) begin
      if (rd_zero && runcnt_r == '0) start_r <= idx_r;
      if (sts.hit) res_rs_r <= (runcnt_r == '0) ? idx_r : start_r;
      // Wrap to cluster 2 at the end of the forward pass, never joining a run across it
      if (sts.pass_end && sts.wrap_ok) begin
        idx_r    <= 16'd2;
        end_r    <= hint_r - 16'd1;
        fwd_r    <= 1'b0;
        runcnt_r <= '0;
      end else begin
        idx_r    <= idx_r + 16'd1;
        runcnt_r <= rd_zero ? (runcnt_r + NW'(1)) : '0;
      end
    end
    if (cmd.srch_fail) res_st_r <= ST_NORUN;
    // Free the old links, then lay down the new run
    if (cmd.free_init) begin
      cur_r <= cl_r;
      i_r   <= '0;
    end
    if (cmd.free_load) begin
      cur_r <= rdata_r;
      i_r   <= i_r + NW'(1);
    end
    if (cmd.fill_init) i_r <= '0;
    if (cmd.fill_step) i_r <= i_r + NW'(1);
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_read_data   <= res_rd_r;
      out_chain_count <= (res_cnt_r > NW'(COUNT_MAX)) ? 13'(COUNT_MAX) : res_cnt_r[12:0];
      out_run_start   <= res_rs_r[11:0];
      out_is_linear   <= res_lin_r;
      out_status      <= res_st_r;
    end
  end

endmodule

[src/fcce_chk.sv]
`timescale 1ns / 1ps
// Port-level checker for the FAT cluster chain engine, bound to the top level.
// Depends on fcce_pkg and fat_cluster_chain_engine_core.
module fcce_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] out_read_data,
  input logic [12:0] out_chain_count,
  input logic [11:0] out_run_start,
  input logic        out_is_linear,
  input logic [1:0]  out_status
);
  import fcce_pkg::*;

  // Hold a stalled result
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_hold_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_status) && $stable(out_run_start))
    else $error("stalled result changed");

  // Status code never takes the unused value
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_OK || out_status == ST_RANGE || out_status == ST_NORUN))
    else $error("bad status code");

  // A failed search reports no run
  a_norun_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_NORUN |-> out_run_start == 12'd0)
    else $error("run start given with no free run");

  // Linear contiguity results carry nothing else
  a_linear_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_linear |-> out_status == ST_OK && out_chain_count == 13'd0
                                   && out_read_data == 16'd0 && out_run_start == 12'd0)
    else $error("linear flag with other fields set");

endmodule

bind fat_cluster_chain_engine_core fcce_chk u_chk (.*);

[verif/tb_fat_cluster_chain_engine_core.sv]
`timescale 1ns / 1ps
// Self-checking testbench for fat_cluster_chain_engine_core: directed and random commands,
// predicted by an in-bench table model and compared field by field. Depends on fcce_pkg.
module tb_fat_cluster_chain_engine_core;
  import fcce_pkg::*;

  localparam int LIMIT = 6000000;

  typedef struct {
    logic [2:0]  op;
    logic [11:0] cl;
    logic [15:0] val;
    logic [12:0] need;
    logic [11:0] hint;
  } fat_cmd_t;

  typedef struct {
    logic [15:0] rd;
    logic [12:0] cnt;
    logic [11:0] rs;
    logic        lin;
    logic [1:0]  st;
  } fat_res_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_opcode = '0;
  logic [11:0] in_cluster = '0;
  logic [15:0] in_entry_value = '0;
  logic [12:0] in_run_length = '0;
  logic [11:0] in_search_from = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] out_read_data;
  logic [12:0] out_chain_count;
  logic [11:0] out_run_start;
  logic        out_is_linear;
  logic [1:0]  out_status;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  fat_cluster_chain_engine_core dut (.*);

  always #5 clk = ~clk;

  // Table model and its registers
  logic [15:0] fat_mem [4096];
  int unsigned total_cl = TOTAL_RST;
  int unsigned end_min = CHAIN_END_RST;

  fat_cmd_t pend_cmds[$];
  fat_res_t due_results[$];
  fat_cmd_t cur_cmd;
  int       gap_left = 0;
  int       stall_left = 0;
  bit       quiet_in = 0, quiet_out = 0;
  bit       hold_req = 0, hold_done = 0;
  int       hold_left = 0;
  int       fail_cnt = 0;
  int       checked = 0;
  int       op_seen [8];
  int       cycles = 0;

  function automatic int unsigned last_idx();
    int unsigned l;
    l = total_cl + 1;
    if (l > 4095) l = 4095;
    return l;
  endfunction

  function automatic bit links_on(int unsigned c);
    return c >= 2 && c < end_min;
  endfunction

  function automatic int unsigned walk_len(int unsigned start, output bit bad);
    int unsigned c, n;
    c = start;
    n = 0;
    bad = 0;
    while (links_on(c) && n <= 4095) begin
      if (c > last_idx()) begin
        bad = 1;
        break;
      end
      c = fat_mem[c];
      n++;
    end
    return n;
  endfunction

  function automatic int unsigned scan_free(int unsigned from, int unsigned upto,
                                            int unsigned need);
    int unsigned s, n;
    s = 0;
    n = 0;
    for (int unsigned i = from; i <= upto; i++) begin
      if (fat_mem[i] == 16'd0) begin
        if (n == 0) s = i;
        n++;
        if (n >= need) return s;
      end else n = 0;
    end
    return 0;
  endfunction

  function automatic int unsigned first_fit(int unsigned need, int unsigned hint);
    int unsigned l, got;
    l = last_idx();
    if (need == 0) need = 1;
    if (l < 2) return 0;
    if (hint < 2 || hint > l) hint = 2;
    got = scan_free(hint, l, need);
    if (got != 0) return got;
    if (hint > 2) return scan_free(2, hint - 1, need);
    return 0;
  endfunction

  // Work out the result of one command and apply its table side effects
  function automatic fat_res_t fat_predict(fat_cmd_t c);
    fat_res_t r;
    int unsigned cl, l, n, cur, prev, steps, nxt, rs;
    bit bad, first;
    r = '{default: '0};
    cl = c.cl;
    l = last_idx();
    case (c.op)
      OP_WRITE: if (cl > l) r.st = ST_RANGE; else fat_mem[cl] = c.val;
      OP_READ:  if (cl > l) r.st = ST_RANGE; else r.rd = fat_mem[cl];
      OP_CHAIN: begin
        n = walk_len(cl, bad);
        r.cnt = 13'((n > COUNT_MAX) ? COUNT_MAX : n);
        if (bad) r.st = ST_RANGE;
      end
      OP_CONTIG: begin
        cur = cl;
        prev = 0;
        steps = 0;
        first = 1;
        r.lin = 1;
        while (links_on(cur) && steps <= 4095) begin
          if (cur > l) begin
            r.st = ST_RANGE;
            r.lin = 0;
            break;
          end
          if (!first && cur != ((prev + 1) & 16'hFFFF)) begin
            r.lin = 0;
            break;
          end
          first = 0;
          prev = cur;
          cur = fat_mem[cur];
          steps++;
        end
      end
      OP_FIND: begin
        r.rs = 12'(first_fit(c.need, c.hint));
        if (r.rs == 0) r.st = ST_NORUN;
      end
      OP_RELOCATE: begin
        n = walk_len(cl, bad);
        r.cnt = 13'((n > COUNT_MAX) ? COUNT_MAX : n);
        if (bad) r.st = ST_RANGE;
        else if (n != 0) begin
          rs = first_fit(n, 2);
          if (rs == 0) r.st = ST_NORUN;
          else begin
            r.rs = 12'(rs);
            cur = cl;
            // free the old links, then lay down the new run
            for (int unsigned i = 0; i < n && links_on(cur) && cur <= l; i++) begin
              nxt = fat_mem[cur];
              fat_mem[cur] = 16'd0;
              cur = nxt;
            end
            for (int unsigned i = 0; i + 1 < n; i++) fat_mem[rs + i] = 16'(rs + i + 1);
            fat_mem[rs + n - 1] = END_MARK;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic int pick_gap(bit quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Input driver: predict on each accepted transfer, then offer the next command
  always @(posedge clk) begin
    bit nv;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if ($urandom_range(0, 199) == 0) quiet_in = ~quiet_in;
      nv = in_valid;
      if (in_valid && !in_stall) begin
        due_results.push_back(fat_predict(cur_cmd));
        op_seen[cur_cmd.op]++;
        nv = 1'b0;
      end
      if (!nv) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pend_cmds.size() > 0) begin
          cur_cmd = pend_cmds.pop_front();
          in_opcode <= cur_cmd.op;
          in_cluster <= cur_cmd.cl;
          in_entry_value <= cur_cmd.val;
          in_run_length <= cur_cmd.need;
          in_search_from <= cur_cmd.hint;
          nv = 1'b1;
          gap_left = pick_gap(quiet_in);
        end
      end
      in_valid <= nv;
    end
  end

  // Receiver stall: random gaps plus one long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if ($urandom_range(0, 199) == 0) quiet_out = ~quiet_out;
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (hold_req && !hold_done) begin
        hold_done = 1;
        hold_left = 400;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        stall_left = pick_gap(quiet_out);
        out_stall <= (stall_left > 0);
      end
    end
  end

  // Result monitor and run limit
  always @(posedge clk) begin
    fat_res_t e;
    cycles++;
    if (cycles > LIMIT) begin
      $display("tb_fat_cluster_chain_engine_core: FAIL");
      $finish;
    end
    if (rst_n && out_valid && !out_stall) begin
      if (due_results.size() == 0) begin
        $error("result transfer with nothing outstanding");
        fail_cnt++;
      end else begin
        e = due_results.pop_front();
        checked++;
        if (out_read_data !== e.rd) begin
          $error("read_data: expected %0h, got %0h", e.rd, out_read_data);
          fail_cnt++;
        end
        if (out_chain_count !== e.cnt) begin
          $error("chain_count: expected %0d, got %0d", e.cnt, out_chain_count);
          fail_cnt++;
        end
        if (out_run_start !== e.rs) begin
          $error("run_start: expected %0d, got %0d", e.rs, out_run_start);
          fail_cnt++;
        end
        if (out_is_linear !== e.lin) begin
          $error("is_linear: expected %0b, got %0b", e.lin, out_is_linear);
          fail_cnt++;
        end
        if (out_status !== e.st) begin
          $error("status: expected %0d, got %0d", e.st, out_status);
          fail_cnt++;
        end
      end
    end
  end

  task automatic add(int unsigned op, int unsigned cl, int unsigned val = 0,
                     int unsigned need = 0, int unsigned hint = 0);
    fat_cmd_t c;
    c = '{op: 3'(op), cl: 12'(cl), val: 16'(val), need: 13'(need), hint: 12'(hint)};
    pend_cmds.push_back(c);
  endtask

  // Hold until every command is taken and every result checked
  task automatic drain();
    do @(negedge clk);
    while (pend_cmds.size() > 0 || in_valid || due_results.size() > 0);
    repeat (20) @(negedge clk);
  endtask

  task automatic reg_write(logic idx, logic [31:0] v);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk);
    while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_TOTAL) total_cl = v[11:0];
    else end_min = v[15:0];
  endtask

  // Zero every entry in a range so that no walk or search meets an unwritten one
  task automatic clear_span(int unsigned from, int unsigned upto);
    for (int unsigned i = from; i <= upto; i++) add(OP_WRITE, i, 16'd0);
  endtask

  task automatic gen_random(int n, int unsigned last);
    int r, len, k;
    int unsigned s, node, prevn;
    k = 0;
    while (k < n) begin
      r = $urandom_range(0, 99);
      if (r < 25) begin
        // well-formed chain with random placement, then walk and relocate it
        s = $urandom_range(2, last);
        len = $urandom_range(1, 5);
        prevn = s;
        for (int j = 1; j < len; j++) begin
          node = $urandom_range(0, 1) ? prevn + 1 : $urandom_range(2, last);
          if (node > last) node = 2;
          add(OP_WRITE, prevn, node);
          prevn = node;
          k++;
        end
        add(OP_WRITE, prevn, $urandom_range(0, 3) == 0 ? $urandom_range(end_min, 65535)
                                                       : END_MARK);
        add($urandom_range(OP_CHAIN, OP_CONTIG), s);
        add(OP_RELOCATE, s);
        k += 3;
      end else if (r < 40) begin
        case ($urandom_range(0, 3))
          0: node = 0;
          1: node = END_MARK;
          2: node = $urandom_range(2, last + 2);
          default: node = $urandom_range(0, 65535);
        endcase
        add(OP_WRITE, $urandom_range(0, 9) == 0 ? $urandom_range(0, 4095)
                                                : $urandom_range(0, last), node);
        k++;
      end else begin
        s = $urandom_range(0, 7) == 0 ? $urandom_range(0, 4095) : $urandom_range(0, last);
        if (r < 50) add(OP_READ, s);
        else if (r < 60) add(OP_CHAIN, s);
        else if (r < 68) add(OP_CONTIG, s);
        else if (r < 82)
          add(OP_FIND, $urandom_range(0, 4095), $urandom_range(0, 65535),
              $urandom_range(0, 19) == 0 ? $urandom_range(0, 4096) : $urandom_range(0, 6),
              $urandom_range(0, 4095));
        else if (r < 95) add(OP_RELOCATE, s);
        else add($urandom_range(6, 7), $urandom_range(0, 4095), $urandom_range(0, 65535),
                 $urandom_range(0, 8191), $urandom_range(0, 4095));
        k++;
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Small volume: clear it, then directed cases
    reg_write(REG_TOTAL, 32'd30);
    clear_span(0, 31);
    add(OP_WRITE, 10, 11);
    add(OP_WRITE, 11, 12);
    add(OP_WRITE, 12, END_MARK);
    add(OP_CHAIN, 10);
    add(OP_CONTIG, 10);
    add(OP_WRITE, 20, 22);
    add(OP_WRITE, 22, END_MARK);
    add(OP_CONTIG, 20);
    add(OP_READ, 10);
    add(OP_READ, 12'hFFF);
    add(OP_WRITE, 12'hFFF, 16'hFFFF);
    add(OP_WRITE, 30, 100);
    add(OP_CHAIN, 30);
    add(OP_CONTIG, 30);
    add(OP_RELOCATE, 30);
    add(OP_CHAIN, 0);
    add(OP_CONTIG, 1);
    add(OP_FIND, 0, 16'h5555, 13'd0, 12'd0);
    add(OP_FIND, 12'hAAA, 16'hAAAA, 13'd4096, 12'hFFF);
    add(OP_FIND, 0, 0, 13'd5, 12'd40);
    add(OP_RELOCATE, 20);
    add(OP_RELOCATE, 12);
    add(3'd6, 12'hFFF, 16'hFFFF, 13'h1FFF, 12'hFFF);
    add(3'd7, 0, 0, 0, 0);
    add(OP_WRITE, 30, 0);
    hold_req = 1;
    gen_random(40, 31);
    drain();

    // Chain end threshold at both extremes
    reg_write(REG_CHAIN_END, 32'd2);
    gen_random(10, 31);
    drain();
    reg_write(REG_CHAIN_END, 32'd65535);
    gen_random(10, 31);
    drain();
    reg_write(REG_CHAIN_END, 32'd65528);

    // Smallest volume: nothing to search
    reg_write(REG_TOTAL, 32'd0);
    add(OP_FIND, 0, 0, 1, 0);
    add(OP_READ, 1);
    add(OP_WRITE, 2, 16'h1234);
    add(OP_RELOCATE, 2);
    drain();

    // Full tiny volume: relocate cannot find room
    reg_write(REG_TOTAL, 32'd4);
    add(OP_WRITE, 2, 3);
    add(OP_WRITE, 3, END_MARK);
    add(OP_WRITE, 4, END_MARK);
    add(OP_WRITE, 5, END_MARK);
    add(OP_RELOCATE, 2);
    add(OP_FIND, 0, 0, 1, 5);
    drain();

    // Largest volume: free room low in the table so searches end before unwritten entries
    reg_write(REG_TOTAL, 32'd4094);
    clear_span(32, 39);
    add(OP_WRITE, 4094, 4095);
    add(OP_WRITE, 4095, END_MARK);
    add(OP_READ, 4095);
    add(OP_CHAIN, 4094);
    add(OP_CONTIG, 4094);
    add(OP_FIND, 0, 0, 13'd3, 12'd36);
    add(OP_RELOCATE, 4094);
    drain();

    $display("Checked %0d results: write %0d, read %0d, chain %0d, contiguity %0d,",
             checked, op_seen[0], op_seen[1], op_seen[2], op_seen[3]);
    $display("  find %0d, relocate %0d, unused %0d; volume sizes 0 to 4094",
             op_seen[4], op_seen[5], op_seen[6] + op_seen[7]);
    if (fail_cnt == 0) $display("tb_fat_cluster_chain_engine_core: PASS");
    else $display("tb_fat_cluster_chain_engine_core: FAIL");
    $finish;
  end

endmodule

[fat_cluster_chain_engine_core.f]
src/fcce_pkg.sv
src/fcce_ctrl.sv
src/fcce_dp.sv
src/fat_cluster_chain_engine_core.sv
src/fcce_chk.sv
verif/tb_fat_cluster_chain_engine_core.sv
